FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is asserted
`define SCAW_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define SCAW_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/scaw_pkg.sv
`timescale 1ns / 1ps

package scaw_pkg;

	localparam int DEPTH_W  = 24;
	localparam int FRAC_W   = 16;
	localparam int ADJ_W    = 17;
	localparam int SUM_W    = 40;
	localparam int PROD_A_W = FRAC_W + ADJ_W;
	localparam int PROD_W   = PROD_A_W + DEPTH_W;
	localparam int TERM_W   = PROD_W - 32 + 2;
	localparam int STEP_W   = 3;

	localparam logic signed [SUM_W:0] SUM_POS_LIM = 41'sd549755813887;
	localparam logic signed [SUM_W:0] SUM_NEG_LIM = -41'sd549755813887;
	localparam logic signed [SUM_W-1:0] AW_MAX_S  = 40'sd16777215;
	localparam logic [DEPTH_W-1:0] AW_MAX         = 24'hFFFFFF;

	typedef enum logic [STEP_W-1:0] {
		ST_WAIT,
		ST_LAYER,
		ST_LAYER_MUL,
		ST_LAYER_ACC,
		ST_DEEP,
		ST_DEEP_MUL,
		ST_DEEP_ACC,
		ST_EMIT
	} step_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_ALWAYS,
		JMP_NOT_LAST
	} jmp_t;

	typedef struct packed {
		logic  wait_in;
		logic  do_layer;
		logic  do_deep;
		logic  do_mul1;
		logic  do_mul2;
		logic  do_acc;
		logic  do_emit;
		jmp_t  jmp;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic in_fire;
		logic last;
		logic out_busy;
	} scaw_stat_t;

	// microcode rom: one control word per step
	function automatic ctl_t ucode(step_t s);
		ctl_t w;
		w = '0;
		w.jmp = JMP_NONE;
		w.target = ST_WAIT;
		case (s)
			ST_WAIT: begin
				w.wait_in = 1'b1;
			end
			ST_LAYER: begin
				w.do_layer = 1'b1;
				w.do_mul1 = 1'b1;
			end
			ST_LAYER_MUL: begin
				w.do_mul2 = 1'b1;
			end
			ST_LAYER_ACC: begin
				w.do_acc = 1'b1;
				w.jmp = JMP_NOT_LAST;
				w.target = ST_WAIT;
			end
			ST_DEEP: begin
				w.do_deep = 1'b1;
				w.do_mul1 = 1'b1;
			end
			ST_DEEP_MUL: begin
				w.do_mul2 = 1'b1;
			end
			ST_DEEP_ACC: begin
				w.do_acc = 1'b1;
			end
			ST_EMIT: begin
				w.do_emit = 1'b1;
				w.jmp = JMP_ALWAYS;
				w.target = ST_WAIT;
			end
			default: begin
				w.wait_in = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: design/scaw_seq.sv
`timescale 1ns / 1ps

module scaw_seq import scaw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scaw_stat_t stat,
	output ctl_t       ctl
);

	step_t step_q;
	step_t step_d;
	logic  hold;
	logic  taken;

	always_comb begin
		ctl = ucode(step_q);
	end

	always_comb begin
		hold = (ctl.wait_in && !stat.in_fire) || (ctl.do_emit && stat.out_busy);
		case (ctl.jmp)
			JMP_ALWAYS:   taken = 1'b1;
			JMP_NOT_LAST: taken = !stat.last;
			default:      taken = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (taken) begin
			step_d = ctl.target;
		end else begin
			step_d = step_t'(STEP_W'(step_q) + STEP_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

FILE: design/soil_column_available_water_top.sv
`timescale 1ns / 1ps
// a layer transaction is taken only in the wait step; the layer, multiply and accumulate
// steps follow, and a last layer then runs the deep steps and registers the result in emit
// the two multiply steps set the pace: two products per water term,
// one term per layer and a second term for the deep layer on the last one
// reset clears the step counter, column state, latched depths and output valid
module soil_column_available_water_top import scaw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 first_layer,
	input  logic                 last_layer,
	input  logic [DEPTH_W-1:0]   total_depth,
	input  logic [DEPTH_W-1:0]   table_depth,
	input  logic [DEPTH_W-1:0]   layer_thickness,
	input  logic [FRAC_W-1:0]    porosity,
	input  logic [FRAC_W-1:0]    field_capacity,
	input  logic [ADJ_W-1:0]     storage_adjust,
	input  logic [ADJ_W-1:0]     deep_adjust,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DEPTH_W-1:0]   available_water,
	output logic                 was_negative,
	output logic                 saturated
);

	ctl_t       ctl;
	scaw_stat_t stat;
	logic       in_fire;
	logic       emit_en;

	// column state
	logic [DEPTH_W-1:0]      depth_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    full_q;
	logic [DEPTH_W-1:0]      total_q;
	logic [DEPTH_W-1:0]      table_q;

	// captured transaction
	logic               last_q;
	logic [DEPTH_W-1:0] thick_q;
	logic [FRAC_W-1:0]  frac_mag_q;
	logic               frac_neg_q;
	logic [ADJ_W-1:0]   adj_q;
	logic [ADJ_W-1:0]   dadj_q;

	// term datapath
	logic [DEPTH_W-1:0]  sat_mag_q;
	logic                sat_neg_q;
	logic                term_en_q;
	logic [PROD_A_W-1:0] prod_a_q;
	logic [PROD_W-1:0]   prod_q;

	// output register
	logic               out_valid_q;
	logic [DEPTH_W-1:0] aw_q;
	logic               neg_q;
	logic               satf_q;

	logic [FRAC_W:0]    frac_diff;
	logic               frac_neg;
	logic [FRAC_W-1:0]  frac_mag;

	logic               full_now;
	logic [DEPTH_W-1:0] rem;
	logic [DEPTH_W-1:0] new_depth;
	logic [DEPTH_W-1:0] ldiff;
	logic [DEPTH_W-1:0] lsat;
	logic               l_term_en;

	logic [DEPTH_W:0]   diff_tt;
	logic [DEPTH_W-1:0] deep;
	logic [DEPTH_W-1:0] dsat_mag;
	logic               dsat_neg;
	logic               d_term_en;

	logic [ADJ_W-1:0]          adj_sel;
	logic [PROD_W:0]           rnd;
	logic [TERM_W-2:0]         mag;
	logic signed [TERM_W-1:0]  term;
	logic signed [SUM_W:0]     sum_next;
	logic signed [SUM_W-1:0]   sum_clamped;

	logic [DEPTH_W-1:0] aw_d;
	logic               neg_d;
	logic               satf_d;

	assign in_stall = !ctl.wait_in;
	assign in_fire  = in_valid && !in_stall;
	assign emit_en  = ctl.do_emit && !(out_valid_q && out_stall);

	always_comb begin
		stat.in_fire  = in_fire;
		stat.last     = last_q;
		stat.out_busy = out_valid_q && out_stall;
	end

	scaw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	always_comb begin
		frac_diff = {1'b0, porosity} - {1'b0, field_capacity};
		frac_neg  = frac_diff[FRAC_W];
		frac_mag  = frac_neg ? FRAC_W'((FRAC_W+1)'(0) - frac_diff) : frac_diff[FRAC_W-1:0];
	end

	// root layer: depth advance, clamp at total, saturated part
	always_comb begin
		full_now  = full_q || (depth_q >= total_q);
		rem       = total_q - depth_q;
		new_depth = (thick_q < rem) ? depth_q + thick_q : total_q;
		ldiff     = new_depth - table_q;
		lsat      = (ldiff > thick_q) ? thick_q : ldiff;
		l_term_en = !full_now && (new_depth > table_q);
	end

	// deep layer: may go negative when the table is below the total depth
	always_comb begin
		diff_tt   = {1'b0, total_q} - {1'b0, table_q};
		deep      = total_q - depth_q;
		dsat_neg  = diff_tt[DEPTH_W];
		if (dsat_neg) begin
			dsat_mag = DEPTH_W'((DEPTH_W+1)'(0) - diff_tt);
		end else begin
			dsat_mag = (diff_tt[DEPTH_W-1:0] > deep) ? deep : diff_tt[DEPTH_W-1:0];
		end
		d_term_en = depth_q < total_q;
	end

	// round magnitude half away from zero, then accumulate with saturation
	always_comb begin
		adj_sel  = ctl.do_deep ? dadj_q : adj_q;
		rnd      = {1'b0, prod_q} + ((PROD_W+1)'(1) << 31);
		mag      = rnd[PROD_W:32];
		term     = (frac_neg_q ^ sat_neg_q) ? TERM_W'(0) - $signed({1'b0, mag})
			: $signed({1'b0, mag});
		sum_next = (SUM_W+1)'(sum_q) + (SUM_W+1)'(term);
		if (sum_next > SUM_POS_LIM) begin
			sum_clamped = SUM_POS_LIM[SUM_W-1:0];
		end else if (sum_next < SUM_NEG_LIM) begin
			sum_clamped = SUM_NEG_LIM[SUM_W-1:0];
		end else begin
			sum_clamped = sum_next[SUM_W-1:0];
		end
	end

	always_comb begin
		aw_d   = sum_q[DEPTH_W-1:0];
		neg_d  = 1'b0;
		satf_d = 1'b0;
		if (sum_q < 0) begin
			aw_d  = '0;
			neg_d = 1'b1;
		end else if (sum_q > AW_MAX_S) begin
			aw_d   = AW_MAX;
			satf_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			sum_q   <= '0;
			full_q  <= 1'b0;
			total_q <= '0;
			table_q <= '0;
			last_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				last_q <= last_layer;
				if (first_layer) begin
					total_q <= total_depth;
					table_q <= table_depth;
					depth_q <= '0;
					sum_q   <= '0;
					full_q  <= 1'b0;
				end
			end
			if (ctl.do_layer) begin
				full_q <= full_now || (new_depth >= total_q);
				if (!full_now) begin
					depth_q <= new_depth;
				end
			end
			if (ctl.do_deep && d_term_en) begin
				depth_q <= total_q;
			end
			if (ctl.do_acc && term_en_q) begin
				sum_q <= sum_clamped;
			end
			if (emit_en) begin
				depth_q <= '0;
				sum_q   <= '0;
				full_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			thick_q    <= layer_thickness;
			frac_mag_q <= frac_mag;
			frac_neg_q <= frac_neg;
			adj_q      <= storage_adjust;
			dadj_q     <= deep_adjust;
		end
		if (ctl.do_layer) begin
			sat_mag_q <= lsat;
			sat_neg_q <= 1'b0;
			term_en_q <= l_term_en;
		end
		if (ctl.do_deep) begin
			sat_mag_q <= dsat_mag;
			sat_neg_q <= dsat_neg;
			term_en_q <= d_term_en;
		end
		if (ctl.do_mul1) begin
			prod_a_q <= PROD_A_W'(frac_mag_q) * PROD_A_W'(adj_sel);
		end
		if (ctl.do_mul2) begin
			prod_q <= PROD_W'(prod_a_q) * PROD_W'(sat_mag_q);
		end
		if (emit_en) begin
			aw_q   <= aw_d;
			neg_q  <= neg_d;
			satf_q <= satf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign available_water = aw_q;
	assign was_negative    = neg_q;
	assign saturated       = satf_q;

endmodule

FILE: design/scaw_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scaw_checker import scaw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [DEPTH_W-1:0] available_water,
	input logic               was_negative,
	input logic               saturated
);

	// a held result keeps its value
	`SCAW_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(available_water) && $stable(was_negative) && $stable(saturated), "result changed while stalled")

	`SCAW_ASSERT(a_flags_excl, clk, arst_n, out_valid |-> !(was_negative && saturated), "both clamp flags set")

	`SCAW_ASSERT(a_neg_zero, clk, arst_n, out_valid && was_negative |-> available_water == '0, "negative sum not clamped to zero")

	`SCAW_ASSERT(a_sat_max, clk, arst_n, out_valid && saturated |-> available_water == AW_MAX, "saturated sum not capped")

	// one layer at a time: the sequencer leaves its wait step on every transaction
	`SCAW_ASSERT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall |=> in_stall, "input taken on consecutive cycles")

endmodule

bind soil_column_available_water_top scaw_checker u_scaw_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import scaw_pkg::*;

	localparam int  LIMIT_CYCLES = 400000;
	localparam int  RANDOM_ITEMS = 1200;
	localparam int  HOLD_CYCLES  = 600;
	localparam int  DRAIN_CYCLES = 24;
	localparam longint SUM_LIM   = 64'sd549755813887;

	typedef struct packed {
		logic               first;
		logic               last;
		logic [DEPTH_W-1:0] total;
		logic [DEPTH_W-1:0] wt_depth;
		logic [DEPTH_W-1:0] thick;
		logic [FRAC_W-1:0]  por;
		logic [FRAC_W-1:0]  fc;
		logic [ADJ_W-1:0]   sadj;
		logic [ADJ_W-1:0]   dadj;
		logic               known;
		logic [DEPTH_W-1:0] aw;
		logic               neg;
		logic               sat;
	} layer_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] aw;
		logic               neg;
		logic               sat;
	} water_res_t;

	// directed layers; expected values typed in only where they are obvious
	localparam int N_DIR = 19;
	layer_t dir_rows [N_DIR] = '{
		// after reset the latched total is zero: empty column
		'{1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h000100, 16'h1234, 16'h0100,
			17'h10000, 17'h10000, 1'b1, 24'h000000, 1'b0, 1'b0},
		'{1'b1, 1'b1, 24'h010000, 24'h000000, 24'h010000, 16'hFFFF, 16'h0000,
			17'h10000, 17'h00000, 1'b1, 24'h00FFFF, 1'b0, 1'b0},
		// capacity above porosity
		'{1'b1, 1'b1, 24'h010000, 24'h000000, 24'h010000, 16'h0000, 16'hFFFF,
			17'h10000, 17'h00000, 1'b1, 24'h000000, 1'b1, 1'b0},
		// sum beyond the output range
		'{1'b1, 1'b1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 16'hFFFF, 16'h0000,
			17'h1FFFF, 17'h00000, 1'b1, 24'hFFFFFF, 1'b0, 1'b1},
		'{1'b1, 1'b1, 24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'h0000,
			17'h00000, 17'h00000, 1'b1, 24'h000000, 1'b0, 1'b0},
		// three layers, table mid column, deep layer below
		'{1'b1, 1'b0, 24'h030000, 24'h018000, 24'h010000, 16'hA000, 16'h4000,
			17'h10000, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 24'h000000, 24'h000000, 24'h010000, 16'h9000, 16'h3000,
			17'h0C000, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 24'h000000, 24'h000000, 24'h008000, 16'h8000, 16'h2000,
			17'h10000, 17'h08000, 1'b0, 24'h0, 1'b0, 1'b0},
		// clamped layer keeps full thickness, then layers past the bottom
		'{1'b1, 1'b0, 24'h010000, 24'h004000, 24'h008000, 16'hC000, 16'h1000,
			17'h10000, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 24'h000000, 24'h000000, 24'h020000, 16'hB000, 16'h2000,
			17'h18000, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 24'h000000, 24'h000000, 24'h010000, 16'hFFFF, 16'h0000,
			17'h1FFFF, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 24'h000000, 24'h000000, 24'h004000, 16'h8000, 16'h0000,
			17'h10000, 17'h1FFFF, 1'b0, 24'h0, 1'b0, 1'b0},
		// table below the bottom: negative deep term
		'{1'b1, 1'b1, 24'h020000, 24'h030000, 24'h008000, 16'hC000, 16'h2000,
			17'h10000, 17'h10000, 1'b0, 24'h0, 1'b0, 1'b0},
		// no first layer: column goes on with the latched depths
		'{1'b0, 1'b0, 24'hFFFFFF, 24'h000000, 24'h010000, 16'h4000, 16'h8000,
			17'h10000, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 24'h000000, 24'hFFFFFF, 24'h004000, 16'hF000, 16'h0100,
			17'h1FFFF, 17'h10000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
			17'h1FFFF, 17'h00000, 1'b0, 24'h0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 24'h000000, 24'h000000, 24'hFFFFFF, 16'hFFFF, 16'h0000,
			17'h1FFFF, 17'h1FFFF, 1'b0, 24'h0, 1'b0, 1'b0},
		// layer bottom exactly at the table
		'{1'b1, 1'b1, 24'h020000, 24'h010000, 24'h010000, 16'h7000, 16'h1000,
			17'h10000, 17'h0C000, 1'b0, 24'h0, 1'b0, 1'b0},
		// zero thickness: whole column is the deep layer
		'{1'b1, 1'b1, 24'h028000, 24'h000000, 24'h000000, 16'h5555, 16'h1111,
			17'h10000, 17'h10000, 1'b0, 24'h0, 1'b0, 1'b0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               first_layer = 1'b0;
	logic               last_layer = 1'b0;
	logic [DEPTH_W-1:0] total_depth = '0;
	logic [DEPTH_W-1:0] table_depth = '0;
	logic [DEPTH_W-1:0] layer_thickness = '0;
	logic [FRAC_W-1:0]  porosity = '0;
	logic [FRAC_W-1:0]  field_capacity = '0;
	logic [ADJ_W-1:0]   storage_adjust = '0;
	logic [ADJ_W-1:0]   deep_adjust = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [DEPTH_W-1:0] available_water;
	logic               was_negative;
	logic               saturated;

	soil_column_available_water_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.first_layer     (first_layer),
		.last_layer      (last_layer),
		.total_depth     (total_depth),
		.table_depth     (table_depth),
		.layer_thickness (layer_thickness),
		.porosity        (porosity),
		.field_capacity  (field_capacity),
		.storage_adjust  (storage_adjust),
		.deep_adjust     (deep_adjust),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.available_water (available_water),
		.was_negative    (was_negative),
		.saturated       (saturated)
	);

	always #4 clk = ~clk;

	// predictor copy of the column state
	logic [DEPTH_W-1:0] col_depth = '0;
	longint             col_sum = 0;
	logic               col_full = 1'b0;
	logic [DEPTH_W-1:0] lat_total = '0;
	logic [DEPTH_W-1:0] lat_wt = '0;

	layer_t     layer_q [$];
	water_res_t water_q [$];
	int         errors = 0;
	int         results_seen = 0;
	int         neg_seen = 0;
	int         sat_seen = 0;
	int         layers_sent = 0;
	int         cycles = 0;

	// exact product reduced to Q8.16, magnitude rounded half away from zero
	function automatic longint water_term(longint frac, longint thick, longint adj);
		longint      p;
		logic [63:0] m;
		p = frac * thick * adj;
		m = (p < 0) ? -p : p;
		m = (m + 64'h8000_0000) >> 32;
		return (p < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic void add_water(longint t);
		longint s;
		s = col_sum + t;
		if (s > SUM_LIM)
			s = SUM_LIM;
		if (s < -SUM_LIM)
			s = -SUM_LIM;
		col_sum = s;
	endfunction

	// advance the column by one layer; returns 1 when a result comes out
	function automatic bit column_step(input layer_t l, output water_res_t r);
		longint             frac;
		logic [DEPTH_W-1:0] rem;
		logic [DEPTH_W-1:0] diff;
		logic [DEPTH_W-1:0] satd;
		longint             deep;
		longint             ddiff;
		longint             dsat;
		r = '0;
		frac = longint'(l.por) - longint'(l.fc);
		if (l.first) begin
			lat_total = l.total;
			lat_wt = l.wt_depth;
			col_depth = '0;
			col_sum = 0;
			col_full = 1'b0;
		end
		if (col_depth >= lat_total)
			col_full = 1'b1;
		if (!col_full) begin
			rem = lat_total - col_depth;
			if (l.thick < rem)
				col_depth = col_depth + l.thick;
			else
				col_depth = lat_total;
			if (col_depth >= lat_total)
				col_full = 1'b1;
			if (col_depth > lat_wt) begin
				diff = col_depth - lat_wt;
				satd = (diff > l.thick) ? l.thick : diff;
				add_water(water_term(frac, longint'(satd), longint'(l.sadj)));
			end
		end
		if (!l.last)
			return 1'b0;
		if (col_depth < lat_total) begin
			deep = longint'(lat_total) - longint'(col_depth);
			ddiff = longint'(lat_total) - longint'(lat_wt);
			dsat = (ddiff > deep) ? deep : ddiff;
			col_depth = lat_total;
			add_water(water_term(frac, dsat, longint'(l.dadj)));
		end
		if (col_sum < 0) begin
			r.neg = 1'b1;
		end else if (col_sum > longint'(AW_MAX)) begin
			r.aw = AW_MAX;
			r.sat = 1'b1;
		end else begin
			r.aw = col_sum[DEPTH_W-1:0];
		end
		col_depth = '0;
		col_sum = 0;
		col_full = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [ADJ_W-1:0] rand_adjust();
		if ($urandom_range(0, 4) == 0)
			return ADJ_W'($urandom_range(0, 131071));
		return ADJ_W'($urandom_range(0, 65536));
	endfunction

	// mostly well-formed columns, some with a missing first or last layer
	task automatic add_random_column();
		layer_t             l;
		int                 n;
		logic [DEPTH_W-1:0] tot;
		logic [DEPTH_W-1:0] wt;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 15) == 0)
			tot = DEPTH_W'($urandom);
		else
			tot = DEPTH_W'($urandom_range(0, 24'h060000));
		if ($urandom_range(0, 3) == 0)
			wt = DEPTH_W'($urandom);
		else
			wt = DEPTH_W'($urandom_range(0, tot));
		for (int k = 0; k < n; k++) begin
			l = '0;
			l.first = (k == 0) ? ($urandom_range(0, 14) != 0) : ($urandom_range(0, 40) == 0);
			l.last = (k == n - 1) ? ($urandom_range(0, 14) != 0) : ($urandom_range(0, 40) == 0);
			l.total = l.first ? tot : 24'($urandom);
			l.wt_depth = l.first ? wt : 24'($urandom);
			if ($urandom_range(0, 9) == 0)
				l.thick = DEPTH_W'($urandom);
			else
				l.thick = DEPTH_W'($urandom_range(0, (tot >> 1) + 24'h100));
			l.por = FRAC_W'($urandom);
			l.fc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, l.por));
			l.sadj = rand_adjust();
			l.dadj = rand_adjust();
			layer_q.push_back(l);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t timeout after %0d cycles, %0d results pending", $time, cycles,
				water_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sender: bursts of layer transactions separated by random gaps
	initial begin
		layer_t     l;
		water_res_t r;
		int         idx;
		int         burst;
		int         gap;
		for (int i = 0; i < N_DIR; i++)
			layer_q.push_back(dir_rows[i]);
		while (layer_q.size() < N_DIR + RANDOM_ITEMS)
			add_random_column();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < layer_q.size()) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			for (int k = 0; k < burst && idx < layer_q.size(); k++) begin
				l = layer_q[idx];
				in_valid <= 1'b1;
				first_layer <= l.first;
				last_layer <= l.last;
				total_depth <= l.total;
				table_depth <= l.wt_depth;
				layer_thickness <= l.thick;
				porosity <= l.por;
				field_capacity <= l.fc;
				storage_adjust <= l.sadj;
				deep_adjust <= l.dadj;
				do
					@(posedge clk);
				while (in_stall);
				if (column_step(l, r)) begin
					if (l.known)
						water_q.push_back('{l.aw, l.neg, l.sat});
					else
						water_q.push_back(r);
				end
				layers_sent++;
				idx++;
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (water_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d layer transactions, checked %0d column results", layers_sent,
			results_seen);
		$display("results clamped at zero: %0d, saturated: %0d", neg_seen, sat_seen);
		if (errors == 0 && water_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver: checks results and stalls on a changing pattern
	initial begin
		water_res_t e;
		int         mode;
		int         mode_left;
		int         hold_left;
		bit         held;
		int         period;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		period = 3;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (water_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result: aw=%h neg=%b sat=%b", $time,
						available_water, was_negative, saturated);
				end else begin
					e = water_q.pop_front();
					neg_seen += int'(e.neg);
					sat_seen += int'(e.sat);
					if (available_water !== e.aw) begin
						errors++;
						$display("%0t available_water: expected %h, actual %h", $time, e.aw,
							available_water);
					end
					if (was_negative !== e.neg) begin
						errors++;
						$display("%0t was_negative: expected %b, actual %b", $time, e.neg,
							was_negative);
					end
					if (saturated !== e.sat) begin
						errors++;
						$display("%0t saturated: expected %b, actual %b", $time, e.sat,
							saturated);
					end
				end
			end

			// long hold-off once, so the block backs up and stalls its input
			if (!held && results_seen == 15) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
				period = $urandom_range(2, 7);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					2: out_stall <= ((cycles % period) != 0);
					default: out_stall <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

endmodule
